@@ hdl/kct_pkg.sv @@
`timescale 1ns / 1ps

package kct_pkg;

    // Table geometry.
    localparam int SLOTS      = 32;
    localparam int COUNT_BITS = 24;
    localparam int IDX_W      = $clog2(SLOTS);

    // Field widths of one request and one result.
    localparam int MODE_W = 2;
    localparam int KEY_W  = 31;
    localparam int AMT_W  = 16;
    localparam int STAT_W = 2;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = ((KEY_W + AMT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((COUNT_BITS + 7) / 8) * 8;

    // Width that holds a count plus an amount without loss.
    localparam int SUM_W = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Request modes. The unused code is served as a check.
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_SATURATED = 2'd3;

    // Read port of the slot store: valid mark, key and count of one slot.
    typedef struct packed {
        logic                  vld;
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] cnt;
    } t_rd;

    // Write port of the slot store.
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      addr;
        logic                  vld;
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] cnt;
    } t_wr;

endpackage

@@ hdl/keyed_count_table.sv @@
`timescale 1ns / 1ps

// Keyed count table: SLOTS entries of a 31-bit key and a COUNT_BITS count, held in
// one synchronous memory with a read port and a write port, with valid marks in
// flip-flops that reset clears. Each request beat (mode in tuser: check, add or
// delete) returns one result beat with the count and a status. The slots are
// searched one per cycle through the memory read port, lowest slot first; a search
// stops at the first match or after the last slot, and each request is finished
// before the next one is taken. The write-back happens before the next search
// starts, so no two accesses to one slot overlap. A finished result waits in an
// output register and does not keep the next request from being taken.

module keyed_count_table
    import kct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // item_key, amount, zero fill
    input  logic [MODE_W-1:0]     s_axis_tuser,   // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // count, zero fill
    output logic [STAT_W-1:0]     m_axis_tuser    // status
);

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    t_rd                   rd;
    t_wr                   wr;
    logic [COUNT_BITS-1:0] res_count;

    // Search and update sequencer with the result register.
    kct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_key       (s_axis_tdata[KEY_W-1:0]),
        .i_amt       (s_axis_tdata[KEY_W+AMT_W-1:KEY_W]),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_count     (res_count),
        .o_status    (m_axis_tuser),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd        (rd),
        .o_wr        (wr)
    );

    // Slot memory and valid marks.
    kct_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .i_wr      (wr)
    );

    assign m_axis_tdata = OUT_DATA_W'(res_count);

endmodule

@@ hdl/kct_store.sv @@
`timescale 1ns / 1ps

module kct_store
    import kct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_rd              o_rd,
    input  t_wr              i_wr
);

    // Key and count of every slot; contents matter only while the slot is valid.
    logic [KEY_W+COUNT_BITS-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]            r_vld;
    logic [KEY_W+COUNT_BITS-1:0] r_rd_data;
    logic                        r_rd_vld;

    // Valid marks, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= i_wr.vld;
        end
    end

    // Memory write; a freed slot keeps its stale contents.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.vld) begin
            r_mem[i_wr.addr] <= {i_wr.key, i_wr.cnt};
        end
    end

    // Registered read: the data follows in the cycle after the read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd.vld = r_rd_vld;
    assign o_rd.key = r_rd_data[KEY_W+COUNT_BITS-1:COUNT_BITS];
    assign o_rd.cnt = r_rd_data[COUNT_BITS-1:0];

endmodule

@@ hdl/kct_ctrl.sv @@
`timescale 1ns / 1ps

module kct_ctrl
    import kct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request side.
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [AMT_W-1:0]      i_amt,
    // Result side.
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [COUNT_BITS-1:0] o_count,
    output logic [STAT_W-1:0]     o_status,
    // Slot store.
    output logic                  o_rd_en,
    output logic [IDX_W-1:0]      o_rd_addr,
    input  t_rd                   i_rd,
    output t_wr                   o_wr
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Request held for the whole scan.
    logic [MODE_W-1:0]     r_mode;
    logic [KEY_W-1:0]      r_key;
    logic [AMT_W-1:0]      r_amt;

    // Scan address, pending read and search results.
    logic [IDX_W-1:0]      r_addr, n_addr;
    logic                  r_issue, n_issue;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pidx, n_pidx;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic                  r_free_ok, n_free_ok;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;

    // Output register.
    logic                  r_ovld, n_ovld;
    logic [COUNT_BITS-1:0] r_ocnt, n_ocnt;
    logic [STAT_W-1:0]     r_ostat, n_ostat;

    // Update path.
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      amt_ext;
    logic [SUM_W-1:0]      max_ext;
    logic [COUNT_BITS-1:0] res_cnt;
    logic [STAT_W-1:0]     res_stat;
    t_wr                   wr;
    logic                  out_free;
    logic                  match;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_ovld;
    assign o_count     = r_ocnt;
    assign o_status    = r_ostat;
    assign o_rd_en     = (r_state == S_SCAN) && r_issue;
    assign o_rd_addr   = r_addr;
    assign out_free    = !r_ovld || i_res_ready;
    assign match       = r_pend && i_rd.vld && (i_rd.key == r_key);

    // Result and write-back of the finished search.
    always_comb begin
        amt_ext  = SUM_W'(r_amt);
        max_ext  = SUM_W'(CNT_MAX);
        sum      = SUM_W'(r_hit_cnt) + amt_ext;
        res_cnt  = '0;
        res_stat = ST_OK;
        wr       = '0;
        wr.key   = r_key;
        unique case (r_mode)
            MODE_ADD: begin
                if (r_hit) begin
                    if (sum > max_ext) begin
                        res_cnt  = CNT_MAX;
                        res_stat = ST_SATURATED;
                    end else begin
                        res_cnt = sum[COUNT_BITS-1:0];
                    end
                    wr.en   = 1'b1;
                    wr.addr = r_hit_idx;
                    wr.vld  = 1'b1;
                    wr.cnt  = res_cnt;
                end else if (r_free_ok) begin
                    if (amt_ext > max_ext) begin
                        res_cnt  = CNT_MAX;
                        res_stat = ST_SATURATED;
                    end else begin
                        res_cnt = amt_ext[COUNT_BITS-1:0];
                    end
                    wr.en   = 1'b1;
                    wr.addr = r_free_idx;
                    wr.vld  = 1'b1;
                    wr.cnt  = res_cnt;
                end else begin
                    res_stat = ST_FULL;
                end
            end
            MODE_DEL: begin
                if (r_hit) begin
                    wr.en   = 1'b1;
                    wr.addr = r_hit_idx;
                    if ((r_amt != '0) && (SUM_W'(r_hit_cnt) > amt_ext)) begin
                        res_cnt = r_hit_cnt - COUNT_BITS'(r_amt);
                        wr.vld  = 1'b1;
                        wr.cnt  = res_cnt;
                    end else begin
                        wr.vld = 1'b0;
                    end
                end else begin
                    res_stat = ST_NOT_FOUND;
                end
            end
            default: begin
                if (r_hit) begin
                    res_cnt = r_hit_cnt;
                end else begin
                    res_stat = ST_NOT_FOUND;
                end
            end
        endcase
    end

    assign o_wr = (r_state == S_DONE && out_free) ? wr : '0;

    // Sequencer: scan the slots in order, stop at the first match or after the last slot.
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_pend     = 1'b0;
        n_pidx     = r_addr;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_cnt  = r_hit_cnt;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_ovld     = r_ovld && !i_res_ready;
        n_ocnt     = r_ocnt;
        n_ostat    = r_ostat;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state   = S_SCAN;
                    n_addr    = '0;
                    n_issue   = 1'b1;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    n_addr = r_addr + 1'b1;
                    if (r_addr == IDX_W'(SLOTS - 1)) begin
                        n_issue = 1'b0;
                    end
                end
                n_pend = r_issue;
                if (r_pend && !i_rd.vld && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_pidx;
                end
                if (match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_pidx;
                    n_hit_cnt = i_rd.cnt;
                    n_state   = S_DONE;
                end else if (r_pend && (r_pidx == IDX_W'(SLOTS - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_ocnt  = res_cnt;
                    n_ostat = res_stat;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_ovld  <= n_ovld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_mode <= i_mode;
            r_key  <= i_key;
            r_amt  <= i_amt;
        end
        r_addr     <= n_addr;
        r_pidx     <= n_pidx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_cnt  <= n_hit_cnt;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_ocnt     <= n_ocnt;
        r_ostat    <= n_ostat;
    end

endmodule

@@ hdl/kct_chk.sv @@
`timescale 1ns / 1ps

module kct_chk
    import kct_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [MODE_W-1:0]     s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STAT_W-1:0]     m_axis_tuser
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // No result beat is offered right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present after reset");

    // Taking a request starts a search, so a request is never taken twice in a row.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while a search runs");

    // A missing key or a full table reports a zero count.
    a_zero_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_FULL)
            |-> m_axis_tdata == '0)
        else $error("nonzero count with missing key or full table");

    // A saturated add reports the largest count.
    a_sat_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_SATURATED
            |-> m_axis_tdata == OUT_DATA_W'(CNT_MAX))
        else $error("saturated status without the largest count");

endmodule

bind keyed_count_table kct_chk u_kct_chk (.*);
